// File: hw/rtl/circle_center_from_three_points_assert.svh
// Assertion macros used by the checker file cc3p_chk.sv
`ifndef CIRCLE_CENTER_FROM_THREE_POINTS_ASSERT_SVH
`define CIRCLE_CENTER_FROM_THREE_POINTS_ASSERT_SVH

// Check on every clock edge once reset is released
`define CC3P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define CC3P_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/cc3p_pkg.sv
package cc3p_pkg;

    // Coordinate width and derived datapath widths
    localparam int CW      = 24;
    localparam int XW      = CW + 2;          // turned point coordinates
    localparam int SW      = CW + 1;          // slope numerator and denominator
    localparam int PW      = SW + XW;         // d*y1, n*x1
    localparam int BW      = PW + 1;          // bisector intercept
    localparam int DLW     = 2 * SW + 1;      // slope cross difference
    localparam int DDW     = 2 * CW;          // d1*d2, unsigned
    localparam int TW      = 24;              // threshold register
    localparam int VSW     = 16;              // vertical slope register
    localparam int RHW     = TW + DDW;        // threshold side of the compare
    localparam int LHW     = DLW + 16;        // slope difference side
    localparam int BLW     = BW / 2;          // low part of a split intercept
    localparam int BHW     = BW - BLW;        // high part, signed
    localparam int PPW     = SW + BLW + 1;    // partial product width
    localparam int NW      = 3 * CW + 5;      // centre numerator
    localparam int DIVD    = DLW + 1;         // divisor width
    localparam int DIV_LAT = CW + 1;          // divider register stages
    localparam int AW      = 3;
    localparam int DW      = 32;

    localparam logic [VSW-1:0] VSLOPE_RST = VSW'(10000);
    localparam logic [TW-1:0]  THRESH_RST = TW'(32768);

    typedef enum logic
    {
        REG_VSLOPE = 1'b0,
        REG_THRESH = 1'b1
    } reg_addr_t;

    typedef struct packed
    {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
    } req_t;

    typedef struct packed
    {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic                 found;
        logic                 saturated;
    } res_t;

    typedef struct packed
    {
        logic signed [XW-1:0] x1;
        logic signed [XW-1:0] y1;
        logic signed [SW-1:0] n;
        logic signed [SW-1:0] d;
    } bis_t;

    typedef struct packed
    {
        logic found;
        logic neg_x;
        logic neg_y;
    } side_t;

    typedef struct packed
    {
        logic [CW-1:0] val;
        logic          sat;
    } coord_t;

    // Bisector of P-Q in half-LSB units, d*y - n*x = b with d > 0
    function automatic bis_t bisector(
        input logic signed [CW-1:0] px,
        input logic signed [CW-1:0] py,
        input logic signed [CW-1:0] qx,
        input logic signed [CW-1:0] qy,
        input logic [VSW-1:0]       vslope
    );
        bis_t r;
        r.x1 = XW'(px) + XW'(qx) - XW'(py) + XW'(qy);
        r.y1 = XW'(py) + XW'(qy) + XW'(px) - XW'(qx);
        if (py == qy)
        begin
            r.n = SW'({1'b0, vslope});
            r.d = SW'(1);
        end
        else if (py > qy)
        begin
            r.n = SW'(qx) - SW'(px);
            r.d = SW'(py) - SW'(qy);
        end
        else
        begin
            r.n = SW'(px) - SW'(qx);
            r.d = SW'(qy) - SW'(py);
        end
        return r;
    endfunction

    // Apply sign and clip a rounded quotient to the coordinate range
    function automatic coord_t clip_coord(
        input logic [CW-1:0] q,
        input logic          ovf,
        input logic          neg
    );
        coord_t r;
        logic [CW:0] lim;
        lim = (CW+1)'(1) << (CW - 1);
        if (neg)
        begin
            if (ovf || ({1'b0, q} > lim))
            begin
                r.sat = 1'b1;
                r.val = lim[CW-1:0];
            end
            else
            begin
                r.sat = 1'b0;
                r.val = CW'(0) - q;
            end
        end
        else
        begin
            if (ovf || q[CW-1])
            begin
                r.sat = 1'b1;
                r.val = lim[CW-1:0] - CW'(1);
            end
            else
            begin
                r.sat = 1'b0;
                r.val = q;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/cc3p_div.sv
module cc3p_div
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [cc3p_pkg::NW-1:0]      num,
    input  logic [cc3p_pkg::DIVD-1:0]    den,
    output logic [cc3p_pkg::CW-1:0]      quot,
    output logic                         ovf
);

    localparam int CW  = cc3p_pkg::CW;
    localparam int NW  = cc3p_pkg::NW;
    localparam int DV  = cc3p_pkg::DIVD;
    localparam int RW  = NW - CW;

    logic [RW-1:0] rem_reg [0:CW-1];
    logic [CW-1:0] low_reg [0:CW-1];
    logic [DV-1:0] den_reg [0:CW-1];
    logic [CW-1:0] q_reg   [0:CW];
    logic          ovf_reg [0:CW];

    // Load: flag a quotient that cannot fit, keep the top dividend bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1:CW];
            low_reg[0] <= num[CW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {1'b0, num} >=
                          {{(NW + 1 - DV - CW){1'b0}}, den, {CW{1'b0}}};
        end
    end

    // One quotient bit per stage, restoring division
    for (genvar i = 1; i <= CW; i++)
    begin : g_step
        logic [RW:0] trial;
        logic [RW:0] diff;
        logic        take;

        always_comb
        begin
            trial = {rem_reg[i-1], low_reg[i-1][CW-1]};
            diff  = trial - {{(RW + 1 - DV){1'b0}}, den_reg[i-1]};
            take  = trial >= {{(RW + 1 - DV){1'b0}}, den_reg[i-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i]   <= {q_reg[i-1][CW-2:0], take};
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end

        if (i < CW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= take ? diff[RW-1:0] : trial[RW-1:0];
                    low_reg[i] <= {low_reg[i-1][CW-2:0], 1'b0};
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end
    end

    assign quot = q_reg[CW];
    assign ovf  = ovf_reg[CW];

endmodule

// File: hw/rtl/circle_center_from_three_points.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   cc3p_pkg::req_t (three points)
// res       out        res_valid/res_stall   cc3p_pkg::res_t (centre, flags)
// apb       in         psel/penable/pready   vertical slope, parallel threshold
//
// One request per cycle while no result is held; each result passes through
// 8 arithmetic stages, a 25-stage divider (a load stage, then one quotient
// bit per stage) and the output register.
// rst_n clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; req_stall follows res_stall
// only while a result is held.
module circle_center_from_three_points
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  cc3p_pkg::req_t              req,
    output logic                        res_valid,
    input  logic                        res_stall,
    output cc3p_pkg::res_t              res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cc3p_pkg::AW-1:0]     paddr,
    input  logic [cc3p_pkg::DW-1:0]     pwdata,
    output logic [cc3p_pkg::DW-1:0]     prdata,
    output logic                        pready
);

    localparam int CW   = cc3p_pkg::CW;
    localparam int SW   = cc3p_pkg::SW;
    localparam int PW   = cc3p_pkg::PW;
    localparam int BW   = cc3p_pkg::BW;
    localparam int BLW  = cc3p_pkg::BLW;
    localparam int DLW  = cc3p_pkg::DLW;
    localparam int DDW  = cc3p_pkg::DDW;
    localparam int TW   = cc3p_pkg::TW;
    localparam int VSW  = cc3p_pkg::VSW;
    localparam int RHW  = cc3p_pkg::RHW;
    localparam int LHW  = cc3p_pkg::LHW;
    localparam int PPW  = cc3p_pkg::PPW;
    localparam int NW   = cc3p_pkg::NW;
    localparam int DV   = cc3p_pkg::DIVD;
    localparam int LAT  = cc3p_pkg::DIV_LAT;
    localparam int DW   = cc3p_pkg::DW;

    logic en;

    // Configuration registers
    logic [VSW-1:0] vslope_reg;
    logic [TW-1:0]  thresh_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vslope_reg <= cc3p_pkg::VSLOPE_RST;
            thresh_reg <= cc3p_pkg::THRESH_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cc3p_pkg::reg_addr_t'(paddr[2]))
                cc3p_pkg::REG_VSLOPE: vslope_reg <= pwdata[VSW-1:0];
                cc3p_pkg::REG_THRESH: thresh_reg <= pwdata[TW-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cc3p_pkg::reg_addr_t'(paddr[2]))
            cc3p_pkg::REG_VSLOPE: prdata = {{(DW - VSW){1'b0}}, vslope_reg};
            cc3p_pkg::REG_THRESH: prdata = {{(DW - TW){1'b0}}, thresh_reg};
            default:              prdata = '0;
        endcase
    end

    // Advance everything unless a result is held
    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    logic [8:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[7:1], req_valid};
    end

    // Stage 1: turned points and slopes of both bisectors
    cc3p_pkg::bis_t bis1_reg, bis2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bis1_reg <= cc3p_pkg::bisector(req.a_x, req.a_y, req.b_x, req.b_y, vslope_reg);
            bis2_reg <= cc3p_pkg::bisector(req.b_x, req.b_y, req.c_x, req.c_y, vslope_reg);
        end
    end

    // Stage 2: intercept products and slope cross products
    logic signed [PW-1:0]  dy1_reg, nx1_reg, dy2_reg, nx2_reg;
    logic signed [DLW-2:0] nd12_reg, nd21_reg;
    logic [DDW-1:0]        dd_reg;
    logic signed [SW-1:0]  n1_2_reg, d1_2_reg, n2_2_reg, d2_2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dy1_reg  <= bis1_reg.d * bis1_reg.y1;
            nx1_reg  <= bis1_reg.n * bis1_reg.x1;
            dy2_reg  <= bis2_reg.d * bis2_reg.y1;
            nx2_reg  <= bis2_reg.n * bis2_reg.x1;
            nd12_reg <= bis1_reg.n * bis2_reg.d;
            nd21_reg <= bis2_reg.n * bis1_reg.d;
            dd_reg   <= bis1_reg.d[CW-1:0] * bis2_reg.d[CW-1:0];
            n1_2_reg <= bis1_reg.n;
            d1_2_reg <= bis1_reg.d;
            n2_2_reg <= bis2_reg.n;
            d2_2_reg <= bis2_reg.d;
        end
    end

    // Stage 3: intercepts and slope difference
    logic signed [BW-1:0]  b1_reg, b2_reg;
    logic signed [DLW-1:0] delta3_reg;
    logic [DDW-1:0]        dd3_reg;
    logic signed [SW-1:0]  n1_3_reg, d1_3_reg, n2_3_reg, d2_3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg     <= BW'(dy1_reg) - BW'(nx1_reg);
            b2_reg     <= BW'(dy2_reg) - BW'(nx2_reg);
            delta3_reg <= DLW'(nd12_reg) - DLW'(nd21_reg);
            dd3_reg    <= dd_reg;
            n1_3_reg   <= n1_2_reg;
            d1_3_reg   <= d1_2_reg;
            n2_3_reg   <= n2_2_reg;
            d2_3_reg   <= d2_2_reg;
        end
    end

    // Stage 4: split products against the intercepts, threshold products
    logic signed [BW-BLW-1:0] b1_hi, b2_hi;
    logic signed [BLW:0]      b1_lo, b2_lo;
    logic [DLW-1:0]           adelta3;

    always_comb
    begin
        b1_hi   = $signed(b1_reg[BW-1:BLW]);
        b2_hi   = $signed(b2_reg[BW-1:BLW]);
        b1_lo   = $signed({1'b0, b1_reg[BLW-1:0]});
        b2_lo   = $signed({1'b0, b2_reg[BLW-1:0]});
        adelta3 = delta3_reg[DLW-1] ? DLW'(-delta3_reg) : DLW'(delta3_reg);
    end

    logic signed [PPW-1:0] d1b2h_reg, d1b2l_reg, d2b1h_reg, d2b1l_reg;
    logic signed [PPW-1:0] n1b2h_reg, n1b2l_reg, n2b1h_reg, n2b1l_reg;
    logic [TW+CW-1:0]      tlo_reg, thi_reg;
    logic [LHW-1:0]        lhs4_reg;
    logic signed [DLW-1:0] delta4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1b2h_reg  <= d1_3_reg * b2_hi;
            d1b2l_reg  <= d1_3_reg * b2_lo;
            d2b1h_reg  <= d2_3_reg * b1_hi;
            d2b1l_reg  <= d2_3_reg * b1_lo;
            n1b2h_reg  <= n1_3_reg * b2_hi;
            n1b2l_reg  <= n1_3_reg * b2_lo;
            n2b1h_reg  <= n2_3_reg * b1_hi;
            n2b1l_reg  <= n2_3_reg * b1_lo;
            tlo_reg    <= thresh_reg * dd3_reg[CW-1:0];
            thi_reg    <= thresh_reg * dd3_reg[DDW-1:CW];
            lhs4_reg   <= {adelta3, 16'b0};
            delta4_reg <= delta3_reg;
        end
    end

    // Stage 5: recombine partial products
    logic signed [NW-1:0]  d1b2_reg, d2b1_reg, n1b2_reg, n2b1_reg;
    logic [RHW-1:0]        rhs5_reg;
    logic [LHW-1:0]        lhs5_reg;
    logic signed [DLW-1:0] delta5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1b2_reg   <= (NW'(d1b2h_reg) <<< BLW) + NW'(d1b2l_reg);
            d2b1_reg   <= (NW'(d2b1h_reg) <<< BLW) + NW'(d2b1l_reg);
            n1b2_reg   <= (NW'(n1b2h_reg) <<< BLW) + NW'(n1b2l_reg);
            n2b1_reg   <= (NW'(n2b1h_reg) <<< BLW) + NW'(n2b1l_reg);
            rhs5_reg   <= (RHW'(thi_reg) << CW) + RHW'(tlo_reg);
            lhs5_reg   <= lhs4_reg;
            delta5_reg <= delta4_reg;
        end
    end

    // Stage 6: centre numerators and the parallel test
    logic signed [NW-1:0]  numx_reg, numy_reg;
    logic                  found6_reg;
    logic signed [DLW-1:0] delta6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg   <= d1b2_reg - d2b1_reg;
            numy_reg   <= n1b2_reg - n2b1_reg;
            found6_reg <= lhs5_reg > rhs5_reg;
            delta6_reg <= delta5_reg;
        end
    end

    // Stage 7: magnitudes and result signs
    logic [NW-1:0]  anx_reg, any_reg;
    logic [DLW-1:0] ad_reg;
    cc3p_pkg::side_t side7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            anx_reg         <= numx_reg[NW-1] ? NW'(-numx_reg) : NW'(numx_reg);
            any_reg         <= numy_reg[NW-1] ? NW'(-numy_reg) : NW'(numy_reg);
            ad_reg          <= delta6_reg[DLW-1] ? DLW'(-delta6_reg) : DLW'(delta6_reg);
            side7_reg.found <= found6_reg;
            side7_reg.neg_x <= numx_reg[NW-1] ^ delta6_reg[DLW-1];
            side7_reg.neg_y <= numy_reg[NW-1] ^ delta6_reg[DLW-1];
        end
    end

    // Stage 8: bias by half the divisor for round-half-away
    logic [NW-1:0]   nx_reg, ny_reg;
    logic [DV-1:0]   den_reg;
    cc3p_pkg::side_t side8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg    <= anx_reg + NW'(ad_reg);
            ny_reg    <= any_reg + NW'(ad_reg);
            den_reg   <= {ad_reg, 1'b0};
            side8_reg <= side7_reg;
        end
    end

    // Dividers, one per coordinate
    logic [CW-1:0] qx, qy;
    logic          ovfx, ovfy;

    cc3p_div u_div_x
    (
        .clk  (clk),
        .en   (en),
        .num  (nx_reg),
        .den  (den_reg),
        .quot (qx),
        .ovf  (ovfx)
    );

    cc3p_div u_div_y
    (
        .clk  (clk),
        .en   (en),
        .num  (ny_reg),
        .den  (den_reg),
        .quot (qy),
        .ovf  (ovfy)
    );

    // Carry valid and side bits alongside the dividers
    logic [LAT-1:0]  dvld_reg;
    cc3p_pkg::side_t dside_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvld_reg <= '0;
        else if (en)
            dvld_reg <= {dvld_reg[LAT-2:0], vld_reg[8]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= side8_reg;
            for (int i = 1; i < LAT; i++)
                dside_reg[i] <= dside_reg[i-1];
        end
    end

    // Output register: clip, sign and zero when no crossing
    cc3p_pkg::coord_t cx, cy;
    cc3p_pkg::res_t   res_next;
    cc3p_pkg::res_t   res_reg;
    logic             res_valid_reg;

    always_comb
    begin
        cx = cc3p_pkg::clip_coord(qx, ovfx, dside_reg[LAT-1].neg_x);
        cy = cc3p_pkg::clip_coord(qy, ovfy, dside_reg[LAT-1].neg_y);
        if (dside_reg[LAT-1].found)
        begin
            res_next.center_x  = cx.val;
            res_next.center_y  = cy.val;
            res_next.found     = 1'b1;
            res_next.saturated = cx.sat | cy.sat;
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dvld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/cc3p_chk.sv
`include "circle_center_from_three_points_assert.svh"

module cc3p_chk
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           res_valid,
    input logic           res_stall,
    input cc3p_pkg::res_t res,
    input logic           pready
);

    // A held result keeps its value
    `CC3P_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result changed while stalled")

    // Requests are only held back by a held result
    `CC3P_ASSERT(a_req_stall, req_stall |-> res_valid && res_stall, "request stalled without a held result")

    // No crossing means a zero centre and no clipping
    `CC3P_ASSERT(a_not_found, res_valid && !res.found |-> res.center_x == 0 && res.center_y == 0 && !res.saturated, "non-zero result without a crossing")

    // Reset empties the output from the next edge on
    `CC3P_ASSERT_ALWAYS(a_reset, !rst_n |=> !res_valid && pready, "output valid after a reset edge")

endmodule

bind circle_center_from_three_points cc3p_chk u_cc3p_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .pready    (pready)
);

// File: test/circle_center_from_three_points_test.sv
`timescale 1ns / 1ps

module circle_center_from_three_points_test;

    typedef logic signed [127:0] wide_t;

    localparam int IDLE_LIMIT = 5000;
    localparam int PIPE_DELAY = 40;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    cc3p_pkg::req_t          req = '0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    cc3p_pkg::res_t          res;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [cc3p_pkg::AW-1:0] paddr = '0;
    logic [cc3p_pkg::DW-1:0] pwdata = '0;
    logic [cc3p_pkg::DW-1:0] prdata;
    logic                    pready;

    // model copy of the registers
    logic [cc3p_pkg::VSW-1:0] vslope_cfg = cc3p_pkg::VSLOPE_RST;
    logic [cc3p_pkg::TW-1:0]  thresh_cfg = cc3p_pkg::THRESH_RST;

    cc3p_pkg::res_t centers_due[$];
    int   error_count = 0;
    int   sent_count = 0;
    int   checked_count = 0;
    int   found_count = 0;
    int   sat_count = 0;
    int   idle_cycles = 0;
    int   hold_left = 0;
    int   stall_pct = 20;
    int   gap_pct = 40;

    circle_center_from_three_points uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Perpendicular bisector of P-Q in half-LSB units: d*y - n*x = b, d > 0
    function automatic void bisect(input wide_t px, input wide_t py, input wide_t qx,
                                   input wide_t qy, output wide_t n, output wide_t d,
                                   output wide_t b);
        wide_t x1;
        wide_t y1;
        x1 = px + qx - (py - qy);
        y1 = py + qy + (px - qx);
        if (py == qy)
        begin
            n = vslope_cfg;
            d = 1;
        end
        else
        begin
            n = qx - px;
            d = py - qy;
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
        end
        b = d * y1 - n * x1;
    endfunction

    // Round num/(2*den) half away from zero and clip to the coordinate range
    function automatic logic [cc3p_pkg::CW-1:0] round_clip(input wide_t num,
                                                           input wide_t den,
                                                           inout logic sat);
        wide_t an;
        wide_t ad;
        wide_t q;
        wide_t lim;
        wide_t mag;
        logic  neg;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an + ad) / (ad + ad);
        lim = wide_t'(1) << (cc3p_pkg::CW - 1);
        mag = q;
        if (neg && q > lim)
        begin
            sat = 1'b1;
            mag = lim;
        end
        else if (!neg && q > lim - 1)
        begin
            sat = 1'b1;
            mag = lim - 1;
        end
        return neg ? cc3p_pkg::CW'(-mag) : cc3p_pkg::CW'(mag);
    endfunction

    function automatic cc3p_pkg::res_t circumcenter(input cc3p_pkg::req_t pts);
        wide_t n1, d1, b1, n2, d2, b2, delta, lhs, rhs;
        cc3p_pkg::res_t r;
        logic  sat;
        r = '0;
        sat = 1'b0;
        bisect(wide_t'(pts.a_x), wide_t'(pts.a_y), wide_t'(pts.b_x), wide_t'(pts.b_y),
               n1, d1, b1);
        bisect(wide_t'(pts.b_x), wide_t'(pts.b_y), wide_t'(pts.c_x), wide_t'(pts.c_y),
               n2, d2, b2);
        delta = n1 * d2 - n2 * d1;
        lhs = ((delta < 0) ? -delta : delta) * 65536;
        rhs = wide_t'(thresh_cfg) * d1 * d2;
        if (lhs > rhs)
        begin
            r.center_x = round_clip(d1 * b2 - d2 * b1, delta, sat);
            r.center_y = round_clip(n1 * b2 - n2 * b1, delta, sat);
            r.found = 1'b1;
            r.saturated = sat;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [cc3p_pkg::CW-1:0] got,
                          input logic [cc3p_pkg::CW-1:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap(input int pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= pct)
            return 0;
        if (r < pct / 10)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receive results, check against the oldest prediction, drive stall
    always @(posedge clk)
    begin
        cc3p_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (centers_due.size() == 0)
            begin
                $display("unexpected result %0h at %0t", res, $realtime);
                error_count++;
            end
            else
            begin
                want = centers_due.pop_front();
                if (res.center_x !== want.center_x)
                    report("center_x", res.center_x, want.center_x);
                if (res.center_y !== want.center_y)
                    report("center_y", res.center_y, want.center_y);
                if (res.found !== want.found)
                    report("found", cc3p_pkg::CW'(res.found), cc3p_pkg::CW'(want.found));
                if (res.saturated !== want.saturated)
                    report("saturated", cc3p_pkg::CW'(res.saturated),
                           cc3p_pkg::CW'(want.saturated));
                checked_count++;
                found_count += want.found;
                sat_count += want.saturated;
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (stall_pct > 0 && $urandom_range(0, 199) == 0)
        begin
            // occasional long hold
            hold_left <= $urandom_range(10, 40);
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", centers_due.size());
            $display("circle_center_from_three_points_test NOT OK");
            $finish;
        end
    end

    // Offer one request and hold it until accepted, then sometimes idle a while
    task automatic send_points(input cc3p_pkg::req_t pts);
        int gap;
        req <= pts;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        centers_due.push_back(circumcenter(pts));
        sent_count++;
        gap = pick_gap(gap_pct);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_six(input int ax, input int ay, input int bx, input int by,
                            input int cx, input int cy);
        cc3p_pkg::req_t p;
        p.a_x = cc3p_pkg::CW'(ax);
        p.a_y = cc3p_pkg::CW'(ay);
        p.b_x = cc3p_pkg::CW'(bx);
        p.b_y = cc3p_pkg::CW'(by);
        p.c_x = cc3p_pkg::CW'(cx);
        p.c_y = cc3p_pkg::CW'(cy);
        send_points(p);
    endtask

    task automatic wait_quiet();
        if (req_valid)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        while (centers_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DELAY) @(posedge clk);
    endtask

    task automatic write_reg(input cc3p_pkg::reg_addr_t idx,
                             input logic [cc3p_pkg::DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == cc3p_pkg::REG_VSLOPE)
            vslope_cfg = value[cc3p_pkg::VSW-1:0];
        else
            thresh_cfg = value[cc3p_pkg::TW-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [cc3p_pkg::VSW-1:0] vs,
                             input logic [cc3p_pkg::TW-1:0] th);
        wait_quiet();
        write_reg(cc3p_pkg::REG_VSLOPE, cc3p_pkg::DW'(vs));
        write_reg(cc3p_pkg::REG_THRESH, cc3p_pkg::DW'(th));
    endtask

    function automatic int coord(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Random triple: raw random bits or points in one of three spans, some with shared y or x
    task automatic send_random();
        int             kind;
        int             span;
        logic [159:0]   raw;
        cc3p_pkg::req_t p;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            p = raw[$bits(cc3p_pkg::req_t)-1:0];
            send_points(p);
        end
        else
        begin
            span = (kind < 60) ? 2000 : ((kind < 85) ? 200000 : 4000000);
            p.a_x = cc3p_pkg::CW'(coord(span));
            p.a_y = cc3p_pkg::CW'(coord(span));
            p.b_x = cc3p_pkg::CW'(coord(span));
            p.b_y = ($urandom_range(0, 9) == 0) ? p.a_y : cc3p_pkg::CW'(coord(span));
            p.c_x = ($urandom_range(0, 19) == 0) ? p.b_x : cc3p_pkg::CW'(coord(span));
            p.c_y = ($urandom_range(0, 9) == 0) ? p.b_y : cc3p_pkg::CW'(coord(span));
            send_points(p);
        end
    endtask

    task automatic test_directed();
        localparam int MX = 8388607;
        localparam int MN = -8388608;
        send_six(0, 0, 256, 256, 512, 0);
        send_six(MX, MX, MN, MN, MX, MN);
        send_six(MN, MX, MX, MN, MN, MN);
        send_six(MN, MN, MN, MN, MN, MN);
        send_six(MX, MX, MX, MX, MX, MX);
        // shared y on one or both segments
        send_six(-100, 50, 100, 50, 300, 400);
        send_six(-100, 50, 100, 75, 300, 75);
        send_six(0, 7, 10, 7, 20, 7);
        // collinear and repeated points
        send_six(0, 0, 100, 100, 200, 200);
        send_six(10, 10, 10, 10, 30, 50);
        send_six(10, 10, 30, 50, 30, 50);
        // nearly parallel bisectors (far centre, clipped), then ordinary triangles
        send_six(0, 0, 1000, 1, 2000, 3);
        send_six(MN, 0, 0, 1, MX, 0);
        send_six(MX, MN, 0, MX, MN, MN + 1);
        send_six(-1, -1, 1, 1, -1, 1);
        send_six(1, 0, 0, 1, -1, 0);
        send_six(MX, 0, 0, MX, MN, 0);
        send_six(0, MN, MX, 0, 0, MX);
        wait_quiet();
    endtask

    task automatic test_random_phase(input int count, input int gp, input int sp);
        gap_pct = gp;
        stall_pct = sp;
        repeat (count) send_random();
    endtask

    // Hold off results long enough that the pipeline fills and stalls requests
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (120) send_random();
        gap_pct = 40;
        stall_pct = 20;
    endtask

    // Pause requests until every result has come back, then resume
    task automatic test_drain_pause();
        repeat (40) send_random();
        wait_quiet();
        repeat (40) send_random();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        configure(16'd1, 24'd0);
        test_directed();
        test_random_phase(250, 40, 20);
        configure(16'hFFFF, 24'hFFFFFF);
        test_directed();
        test_random_phase(250, 0, 0);
        configure(16'd3, 24'd1);
        test_random_phase(250, 70, 50);
        test_backpressure();
        configure(cc3p_pkg::VSLOPE_RST, cc3p_pkg::THRESH_RST);
        test_random_phase(250, 30, 10);
        test_drain_pause();
        wait_quiet();
        $display("sent %0d point triples, checked %0d centres", sent_count, checked_count);
        $display("%0d centres found, %0d clipped, over four register settings",
                 found_count, sat_count);
        if (error_count == 0)
            $display("circle_center_from_three_points_test OK");
        else
            $display("circle_center_from_three_points_test NOT OK");
        $finish;
    end

endmodule

// File: circle_center_from_three_points.f
+incdir+hw/rtl
hw/rtl/cc3p_pkg.sv
hw/rtl/cc3p_div.sv
hw/rtl/circle_center_from_three_points.sv
hw/rtl/cc3p_chk.sv
test/circle_center_from_three_points_test.sv
